// ===== src/wpd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the pixel discriminator.
// Used by every module of the block; depends on nothing.
package wpd_pkg;

  localparam int THERMO_LEVELS_DEF = 128;
  localparam int CHANNELS_DEF      = 3;
  localparam int TUPLE_BITS_DEF    = 16;
  localparam int NUM_TUPLES_DEF    = 24;

  localparam int CMD_W    = 2;
  localparam int MAP_W    = 9;
  localparam int CHAN_W   = 8;
  localparam int IN_CHANS = 3;
  localparam int SEL_W    = 2;
  localparam int LEVEL_W  = 9;
  localparam int HIT_W    = 5;
  localparam int HIT_MAX  = 31;

  localparam logic [HIT_W-1:0] THRESH_RESET = 5'd12;

  // level = floor((2*T*x + 255) / 510) by reciprocal, exact for numerators below 2^17
  localparam int             LVL_SHIFT = 26;
  localparam longint         LVL_RECIP = 131587;
  localparam int             LVL_PROD_W = 35;
  localparam longint         LVL_ROUND = 255 * LVL_RECIP;

  // map value / CHANNELS by reciprocal, exact for 9-bit values and CHANNELS up to 4
  localparam int QUOT_SHIFT  = 18;
  localparam int QUOT_PROD_W = 28;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_TRAIN   = 2'd1,
    CMD_PREDICT = 2'd2,
    CMD_CLEAR   = 2'd3
  } wpd_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [MAP_W-1:0]  map_index;
    logic [MAP_W-1:0]  map_value;
    logic [CHAN_W-1:0] chan0;
    logic [CHAN_W-1:0] chan1;
    logic [CHAN_W-1:0] chan2;
  } wpd_in_t;

  typedef struct packed {
    logic [HIT_W-1:0] hit_count;
    logic             foreground;
  } wpd_out_t;

  // one queued word: command plus its decoded operands
  typedef struct packed {
    wpd_cmd_t                           cmd;
    logic [MAP_W-1:0]                   idx;
    logic [MAP_W-1:0]                   val;
    logic [MAP_W-1:0]                   quot;
    logic [IN_CHANS-1:0][LEVEL_W-1:0]   lvl;
  } wpd_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } wpd_qstat_t;

endpackage

// ===== src/wpd_front.sv =====
`timescale 1ns / 1ps
// Front end: takes command words, converts channels to thermometer levels
// and map values to level thresholds. Depends on wpd_pkg.
module wpd_front
  import wpd_pkg::*;
#(
  parameter int THERMO_LEVELS = THERMO_LEVELS_DEF,
  parameter int CHANNELS      = CHANNELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  wpd_in_t    in_data,
  input  logic       hold,
  input  wpd_qstat_t qstat,
  output logic       busy,
  output logic       push,
  output wpd_item_t  item
);

  localparam longint LVL_K1     = longint'(2 * THERMO_LEVELS) * LVL_RECIP;
  localparam int     QUOT_RECIP = ((1 << QUOT_SHIFT) + CHANNELS - 1) / CHANNELS;

  logic                                valid_r, valid_nxt;
  wpd_item_t                           item_r, item_nxt;
  logic                                accept;
  logic [IN_CHANS-1:0][CHAN_W-1:0]     chan_in;
  logic [LVL_PROD_W-1:0]               lvl_prod [IN_CHANS];
  logic [QUOT_PROD_W-1:0]              quot_prod;

  assign busy      = hold | (valid_r & qstat.full);
  assign accept    = start & ~busy;
  assign push      = valid_r & ~qstat.full;
  assign valid_nxt = accept | (valid_r & qstat.full);
  assign item      = item_r;
  assign chan_in   = {in_data.chan2, in_data.chan1, in_data.chan0};

  always_comb begin
    for (int c = 0; c < IN_CHANS; c++) begin
      lvl_prod[c] = LVL_PROD_W'(chan_in[c]) * LVL_PROD_W'(LVL_K1) + LVL_PROD_W'(LVL_ROUND);
    end
    quot_prod = QUOT_PROD_W'(in_data.map_value) * QUOT_PROD_W'(QUOT_RECIP);

    item_nxt.cmd  = wpd_cmd_t'(in_data.command);
    item_nxt.idx  = in_data.map_index;
    item_nxt.val  = in_data.map_value;
    item_nxt.quot = quot_prod[QUOT_SHIFT +: MAP_W];
    for (int c = 0; c < IN_CHANS; c++) begin
      item_nxt.lvl[c] = lvl_prod[c][LVL_SHIFT +: LEVEL_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== src/wpd_queue.sv =====
`timescale 1ns / 1ps
// Short word queue between front end and back end.
// Depends on wpd_pkg.
module wpd_queue
  import wpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  wpd_item_t  push_item,
  input  logic       pop,
  output wpd_qstat_t stat,
  output wpd_item_t  head
);

  wpd_item_t          entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head       = entries_r[rd_ptr_r];

  // depth is a power of two, so pointers wrap on their own
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== src/wpd_back.sv =====
`timescale 1ns / 1ps
// Back end: bit map registers, tuple memories, train/predict/clear sequencer.
// Depends on wpd_pkg.
module wpd_back
  import wpd_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int TUPLE_BITS = TUPLE_BITS_DEF,
  parameter int NUM_TUPLES = NUM_TUPLES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [HIT_W-1:0] thresh,
  input  wpd_qstat_t       qstat,
  input  wpd_item_t        head,
  output logic             pop,
  output logic             init_busy,
  output logic             out_strobe,
  output wpd_out_t         out_data
);

  localparam int MAP_DEPTH = NUM_TUPLES * TUPLE_BITS;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int IDX_W     = (MAP_AW > MAP_W) ? MAP_AW : MAP_W;
  localparam int MEM_DEPTH = 1 << TUPLE_BITS;
  localparam int GROUPS    = (NUM_TUPLES + 7) / 8;
  localparam int PAD_W     = GROUPS * 8;
  localparam int CNT_W     = $clog2(NUM_TUPLES + 1);
  localparam int CMP_W     = (CNT_W > HIT_W) ? CNT_W : HIT_W;
  localparam int REM_W     = MAP_W + 3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_ACCESS,
    ST_COUNT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [SEL_W-1:0] chan;
    logic [MAP_W-1:0] quot;
  } map_ent_t;

  state_t                  state_r, state_nxt;
  logic                    init_r, init_nxt;
  logic [TUPLE_BITS-1:0]   clr_addr_r, clr_addr_nxt;
  logic                    out_strobe_r, out_strobe_nxt;
  wpd_out_t                out_data_r, out_data_nxt;
  wpd_item_t               item_r, item_nxt;

  map_ent_t                map_r [MAP_DEPTH];
  logic                    map_we;
  logic [IDX_W-1:0]        map_idx;
  map_ent_t                map_wdata;
  logic [REM_W-1:0]        map_rem;

  logic [TUPLE_BITS-1:0]   addr_r [NUM_TUPLES];
  logic [TUPLE_BITS-1:0]   addr_nxt [NUM_TUPLES];
  logic                    mem_we;
  logic                    mem_wbit;
  logic [NUM_TUPLES-1:0]   rd_bits;
  logic [PAD_W-1:0]        rd_pad;
  logic [3:0]              grp_r [GROUPS];
  logic [3:0]              grp_nxt [GROUPS];
  logic [CNT_W-1:0]        hit_sum;
  logic [CMP_W-1:0]        hit_ext;

  assign pop        = (state_r == ST_IDLE) && !qstat.empty;
  assign init_busy  = init_r;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // map load: store channel select and level threshold of the position
  assign map_idx        = IDX_W'(head.idx);
  assign map_rem        = REM_W'(head.val) - REM_W'(head.quot) * REM_W'(CHANNELS);
  assign map_wdata.chan = map_rem[SEL_W-1:0];
  assign map_wdata.quot = head.quot;

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_r[map_idx[MAP_AW-1:0]] <= map_wdata;
    end
  end

  // gather all tuple addresses at once, first slot is the msb
  always_comb begin
    map_ent_t             ent;
    logic [LEVEL_W-1:0]   sel;
    ent = '0;
    sel = '0;
    for (int j = 0; j < NUM_TUPLES; j++) begin
      for (int k = 0; k < TUPLE_BITS; k++) begin
        ent = map_r[MAP_AW'(j * TUPLE_BITS + k)];
        sel = (int'(ent.chan) < IN_CHANS) ? item_r.lvl[ent.chan] : '0;
        addr_nxt[j][TUPLE_BITS-1-k] = (sel > ent.quot);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_TUPLES; j++) begin
      addr_r[j] <= addr_nxt[j];
    end
  end

  for (genvar j = 0; j < NUM_TUPLES; j++) begin : g_tuple
    logic                  mem [MEM_DEPTH];
    logic                  rd_bit_r;
    logic [TUPLE_BITS-1:0] mem_addr;

    assign mem_addr   = (state_r == ST_CLEAR) ? clr_addr_r : addr_r[j];
    assign rd_bits[j] = rd_bit_r;

    always_ff @(posedge clk) begin
      if (mem_we) begin
        mem[mem_addr] <= mem_wbit;
      end
      rd_bit_r <= mem[mem_addr];
    end
  end

  // hit count in two steps: groups of eight, then the group sums
  assign rd_pad = PAD_W'(rd_bits);

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_nxt[g] = '0;
      for (int b = 0; b < 8; b++) begin
        grp_nxt[g] = grp_nxt[g] + 4'(rd_pad[g*8+b]);
      end
    end
    hit_sum = '0;
    for (int g = 0; g < GROUPS; g++) begin
      hit_sum = hit_sum + CNT_W'(grp_r[g]);
    end
    hit_ext = CMP_W'(hit_sum);
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_r[g] <= grp_nxt[g];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    init_nxt       = init_r;
    clr_addr_nxt   = clr_addr_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = '0;
    item_nxt       = item_r;
    map_we         = 1'b0;
    mem_we         = 1'b0;
    mem_wbit       = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr_r == '1) begin
          clr_addr_nxt   = '0;
          init_nxt       = 1'b0;
          out_strobe_nxt = ~init_r;
          state_nxt      = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + TUPLE_BITS'(1);
        end
      end
      ST_IDLE: begin
        if (!qstat.empty) begin
          case (head.cmd)
            CMD_LOAD: begin
              map_we         = (map_idx < IDX_W'(MAP_DEPTH));
              out_strobe_nxt = 1'b1;
            end
            CMD_TRAIN, CMD_PREDICT: begin
              item_nxt  = head;
              state_nxt = ST_ADDR;
            end
            CMD_CLEAR: begin
              clr_addr_nxt = '0;
              state_nxt    = ST_CLEAR;
            end
            default: begin
              out_strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_ADDR: begin
        state_nxt = ST_ACCESS;
      end
      ST_ACCESS: begin
        if (item_r.cmd == CMD_TRAIN) begin
          mem_we         = 1'b1;
          mem_wbit       = 1'b1;
          out_strobe_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          state_nxt = ST_COUNT;
        end
      end
      ST_COUNT: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        out_strobe_nxt          = 1'b1;
        out_data_nxt.hit_count  = (hit_ext > CMP_W'(HIT_MAX)) ? HIT_W'(HIT_MAX)
                                                               : hit_ext[HIT_W-1:0];
        out_data_nxt.foreground = (hit_ext <= CMP_W'(thresh));
        state_nxt               = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      init_r       <= 1'b1;
      clr_addr_r   <= '0;
      out_strobe_r <= 1'b0;
      out_data_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      init_r       <= init_nxt;
      clr_addr_r   <= clr_addr_nxt;
      out_strobe_r <= out_strobe_nxt;
      out_data_r   <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

// ===== src/wisard_pixel_discriminator.sv =====
`timescale 1ns / 1ps
// Top level of the WiSARD pixel discriminator: front end, word queue, back end
// and the hit threshold register. Depends on wpd_pkg, wpd_front, wpd_queue, wpd_back.
//
// Usage: drive in_data and raise start; the word is taken at a clock edge where
// start is high and busy is low. Commands: load a bit map slot, train, predict,
// clear the tuple memories. Every command gives exactly one result word on
// out_data, valid for the single cycle that out_strobe is high; the receiver
// cannot stall it. hit_count and foreground are zero for all but predict.
// cfg_we/cfg_wdata write the hit threshold at any edge while the block is idle.
// The front end registers each accepted word and passes it through the queue to
// the back end sequencer: load writes the map in its idle state, train goes
// through address and access states, predict through address, access, count and
// result, and clear sweeps every tuple memory address; the sequencer works over
// the single-port tuple memories, and the two-word queue lets the front end take
// words while the back end works. After reset the back end sweeps all tuple
// memories to zero with busy held high; no result is given for that sweep. The
// threshold resets to 12.
module wisard_pixel_discriminator
  import wpd_pkg::*;
#(
  parameter int THERMO_LEVELS = THERMO_LEVELS_DEF,
  parameter int CHANNELS      = CHANNELS_DEF,
  parameter int TUPLE_BITS    = TUPLE_BITS_DEF,
  parameter int NUM_TUPLES    = NUM_TUPLES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  wpd_in_t          in_data,
  output logic             out_strobe,
  output wpd_out_t         out_data,
  input  logic             cfg_we,
  input  logic [HIT_W-1:0] cfg_wdata
);

  logic [HIT_W-1:0] thresh_r, thresh_nxt;
  logic             init_busy;
  logic             push;
  logic             pop;
  wpd_item_t        push_item;
  wpd_item_t        head;
  wpd_qstat_t       qstat;

  assign thresh_nxt = cfg_we ? cfg_wdata : thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else begin
      thresh_r <= thresh_nxt;
    end
  end

  wpd_front #(
    .THERMO_LEVELS (THERMO_LEVELS),
    .CHANNELS      (CHANNELS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_data (in_data),
    .hold    (init_busy),
    .qstat   (qstat),
    .busy    (busy),
    .push    (push),
    .item    (push_item)
  );

  wpd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .stat      (qstat),
    .head      (head)
  );

  wpd_back #(
    .CHANNELS   (CHANNELS),
    .TUPLE_BITS (TUPLE_BITS),
    .NUM_TUPLES (NUM_TUPLES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .thresh     (thresh_r),
    .qstat      (qstat),
    .head       (head),
    .pop        (pop),
    .init_busy  (init_busy),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
